// File: sv/tapvc_pkg.sv
// ----------------------------------------------------------------------------
// tapvc_pkg
// Shared types and constants for the two-axis pid velocity controller.
// ----------------------------------------------------------------------------
package tapvc_pkg;

  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int GAIN_W  = 16;
  localparam int LIMIT_W = 15;
  localparam int VEL_W   = 16;

  localparam logic [GAIN_W-1:0]  KP_RST   = 16'd2048;
  localparam logic [GAIN_W-1:0]  KI_RST   = 16'd410;
  localparam logic [GAIN_W-1:0]  KD_RST   = 16'd410;
  localparam logic [LIMIT_W-1:0] VLIM_RST = 15'd2560;

  typedef enum logic [2:0] {
    REG_SETPOINT_X = 3'd0,
    REG_SETPOINT_Y = 3'd1,
    REG_GAIN_PROP  = 3'd2,
    REG_GAIN_INTEG = 3'd3,
    REG_GAIN_DERIV = 3'd4,
    REG_VEL_LIMIT  = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [GAIN_W-1:0]  kp;
    logic [GAIN_W-1:0]  ki;
    logic [GAIN_W-1:0]  kd;
    logic [LIMIT_W-1:0] vlim;
  } gains_t;

  typedef struct packed {
    logic adv;
    logic load;
    logic clr;
  } lane_ctl_t;

endpackage

// File: sv/two_axis_pid_velocity_clamp.sv
// ----------------------------------------------------------------------------
// two_axis_pid_velocity_clamp
// Two-axis pid position controller with symmetric velocity clamp.
// ----------------------------------------------------------------------------
// Takes one position word per clock cycle while the output is not stalled and
// returns its velocity word from an output register. The only loop is
// the per-axis integrator and previous-error update, which completes in the
// accept cycle; the gain products, sums and clamp follow in a four-stage
// pipeline per axis, and the whole pipeline holds while a finished word waits
// at the output. A word with position_valid low is accepted, changes no state
// and yields no result. Writing either setpoint clears both integrators.
module two_axis_pid_velocity_clamp #(
  parameter int POS_WIDTH      = 16,
  parameter int INTEG_WIDTH    = 32,
  parameter int GAIN_FRAC_BITS = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tapvc_pkg::ADDR_W-1:0]        paddr,
  input  logic [tapvc_pkg::DATA_W-1:0]        pwdata,
  output logic [tapvc_pkg::DATA_W-1:0]        prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [POS_WIDTH-1:0]         meas_x_i,
  input  logic signed [POS_WIDTH-1:0]         meas_y_i,
  input  logic                                position_valid_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [tapvc_pkg::VEL_W-1:0]  vel_x_o,
  output logic signed [tapvc_pkg::VEL_W-1:0]  vel_y_o,
  output logic                                clamped_x_o,
  output logic                                clamped_y_o
);
  import tapvc_pkg::*;

  logic signed [POS_WIDTH-1:0] sp_x, sp_y;
  gains_t                      gains;
  logic                        clr;
  lane_ctl_t                   ctl;
  logic                        adv;
  logic [3:0]                  vld_q;
  logic                        out_valid_q;
  logic signed [VEL_W-1:0]     lane_vel_x, lane_vel_y, vel_x_q, vel_y_q;
  logic                        lane_clamp_x, lane_clamp_y, clamped_x_q, clamped_y_q;

  tapvc_regs #(
    .POS_WIDTH (POS_WIDTH)
  ) u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .sp_x_o  (sp_x),
    .sp_y_o  (sp_y),
    .gains_o (gains),
    .clr_o   (clr)
  );

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;
  assign ctl.adv    = adv;
  assign ctl.load   = in_valid_i && adv && position_valid_i;
  assign ctl.clr    = clr;

  tapvc_lane #(
    .POS_WIDTH      (POS_WIDTH),
    .INTEG_WIDTH    (INTEG_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_lane_x (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .gains_i   (gains),
    .sp_i      (sp_x),
    .meas_i    (meas_x_i),
    .vel_o     (lane_vel_x),
    .clamped_o (lane_clamp_x)
  );

  tapvc_lane #(
    .POS_WIDTH      (POS_WIDTH),
    .INTEG_WIDTH    (INTEG_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_lane_y (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .gains_i   (gains),
    .sp_i      (sp_y),
    .meas_i    (meas_y_i),
    .vel_o     (lane_vel_y),
    .clamped_o (lane_clamp_y)
  );

  // stage valid bits and output word merge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q       <= {vld_q[2:0], ctl.load};
      out_valid_q <= vld_q[3];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vel_x_q     <= lane_vel_x;
      vel_y_q     <= lane_vel_y;
      clamped_x_q <= lane_clamp_x;
      clamped_y_q <= lane_clamp_y;
    end
  end

  assign out_valid_o = out_valid_q;
  assign vel_x_o     = vel_x_q;
  assign vel_y_o     = vel_y_q;
  assign clamped_x_o = clamped_x_q;
  assign clamped_y_o = clamped_y_q;

  a_mag_x : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((vel_x_o <= $signed({1'b0, gains.vlim}))
                 && (vel_x_o >= -$signed({1'b0, gains.vlim}))))
    else $error("x velocity beyond limit");

  a_clamp_y : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && clamped_y_o) |-> ((vel_y_o == $signed({1'b0, gains.vlim}))
                                  || (vel_y_o == -$signed({1'b0, gains.vlim}))))
    else $error("clamped y velocity not at limit");

  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> $stable(vld_q))
    else $error("pipeline moved during output stall");

  a_rise_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(vld_q[3]))
    else $error("result word without a pipeline source");

endmodule

// File: sv/tapvc_regs.sv
// ----------------------------------------------------------------------------
// tapvc_regs
// APB register file: setpoints, gains and velocity limit.
// ----------------------------------------------------------------------------
module tapvc_regs #(
  parameter int POS_WIDTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tapvc_pkg::ADDR_W-1:0]     paddr,
  input  logic [tapvc_pkg::DATA_W-1:0]     pwdata,
  output logic [tapvc_pkg::DATA_W-1:0]     prdata,
  output logic                             pready,
  output logic signed [POS_WIDTH-1:0]      sp_x_o,
  output logic signed [POS_WIDTH-1:0]      sp_y_o,
  output tapvc_pkg::gains_t                gains_o,
  output logic                             clr_o
);
  import tapvc_pkg::*;

  logic signed [POS_WIDTH-1:0] sp_x_q, sp_y_q;
  gains_t                      gains_q;
  logic                        wr;
  reg_idx_e                    idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign clr_o  = wr && ((idx == REG_SETPOINT_X) || (idx == REG_SETPOINT_Y));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_x_q       <= '0;
      sp_y_q       <= '0;
      gains_q.kp   <= KP_RST;
      gains_q.ki   <= KI_RST;
      gains_q.kd   <= KD_RST;
      gains_q.vlim <= VLIM_RST;
    end else if (wr) begin
      case (idx)
        REG_SETPOINT_X: sp_x_q       <= pwdata[POS_WIDTH-1:0];
        REG_SETPOINT_Y: sp_y_q       <= pwdata[POS_WIDTH-1:0];
        REG_GAIN_PROP:  gains_q.kp   <= pwdata[GAIN_W-1:0];
        REG_GAIN_INTEG: gains_q.ki   <= pwdata[GAIN_W-1:0];
        REG_GAIN_DERIV: gains_q.kd   <= pwdata[GAIN_W-1:0];
        REG_VEL_LIMIT:  gains_q.vlim <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SETPOINT_X: prdata = DATA_W'(sp_x_q);
      REG_SETPOINT_Y: prdata = DATA_W'(sp_y_q);
      REG_GAIN_PROP:  prdata = DATA_W'(gains_q.kp);
      REG_GAIN_INTEG: prdata = DATA_W'(gains_q.ki);
      REG_GAIN_DERIV: prdata = DATA_W'(gains_q.kd);
      REG_VEL_LIMIT:  prdata = DATA_W'(gains_q.vlim);
      default:        prdata = '0;
    endcase
  end

  assign sp_x_o  = sp_x_q;
  assign sp_y_o  = sp_y_q;
  assign gains_o = gains_q;

endmodule

// File: sv/tapvc_lane.sv
// ----------------------------------------------------------------------------
// tapvc_lane
// One axis: error, saturating integrator, derivative, gain products,
// rounding and velocity clamp, four pipeline stages.
// ----------------------------------------------------------------------------
module tapvc_lane #(
  parameter int POS_WIDTH      = 16,
  parameter int INTEG_WIDTH    = 32,
  parameter int GAIN_FRAC_BITS = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tapvc_pkg::lane_ctl_t                ctl_i,
  input  tapvc_pkg::gains_t                   gains_i,
  input  logic signed [POS_WIDTH-1:0]         sp_i,
  input  logic signed [POS_WIDTH-1:0]         meas_i,
  output logic signed [tapvc_pkg::VEL_W-1:0]  vel_o,
  output logic                                clamped_o
);
  import tapvc_pkg::*;

  localparam int EW   = POS_WIDTH + 1;
  localparam int DW   = POS_WIDTH + 2;
  localparam int SW0  = ((INTEG_WIDTH > EW) ? INTEG_WIDTH : EW) + 1;
  localparam int IL   = INTEG_WIDTH / 2;
  localparam int IH   = INTEG_WIDTH - IL;
  localparam int KW   = GAIN_W + 1;
  localparam int PPW  = EW + KW;
  localparam int PDW  = DW + KW;
  localparam int PLW  = IL + 1 + KW;
  localparam int PHW  = IH + KW;
  localparam int TW   = INTEG_WIDTH + KW;
  localparam int PSW  = PDW + 1;
  localparam int CW   = (TW > 62) ? TW : 62;
  localparam int SUMW = CW + 2;

  localparam logic signed [SW0-1:0]  IMAX = SW0'((64'd1 << (INTEG_WIDTH - 1)) - 64'd1);
  localparam logic signed [SW0-1:0]  IMIN = -IMAX - SW0'(1);
  localparam logic signed [CW-1:0]   TMAX = CW'(64'h1000_0000_0000_0000);
  localparam logic signed [CW-1:0]   TMIN = -TMAX;
  localparam logic signed [SUMW-1:0] HALF = SUMW'(64'd1 << (GAIN_FRAC_BITS - 1));

  // loop-carried state
  logic signed [INTEG_WIDTH-1:0] integ_q, integ_d;
  logic signed [EW-1:0]          last_q;

  logic signed [EW-1:0]  err;
  logic signed [DW-1:0]  dif;
  logic signed [SW0-1:0] isum, isat;

  always_comb begin
    err  = EW'(sp_i) - EW'(meas_i);
    dif  = DW'(err) - DW'(last_q);
    isum = SW0'(integ_q) + SW0'(err);
    if (isum > IMAX) begin
      isat = IMAX;
    end else if (isum < IMIN) begin
      isat = IMIN;
    end else begin
      isat = isum;
    end
    integ_d = isat[INTEG_WIDTH-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      last_q  <= '0;
    end else begin
      if (ctl_i.clr) begin
        integ_q <= '0;
      end else if (ctl_i.load) begin
        integ_q <= integ_d;
      end
      if (ctl_i.load) begin
        last_q <= err;
      end
    end
  end

  // stage 1: operands
  logic signed [EW-1:0]          e1_q;
  logic signed [DW-1:0]          d1_q;
  logic signed [INTEG_WIDTH-1:0] i1_q;

  // stage 2: products
  logic signed [KW-1:0]  kp_s, ki_s, kd_s;
  logic signed [IL:0]    i_lo;
  logic signed [IH-1:0]  i_hi;
  logic signed [PPW-1:0] pp, pp2_q;
  logic signed [PDW-1:0] pd, pd2_q;
  logic signed [PLW-1:0] pl, pl2_q;
  logic signed [PHW-1:0] ph, ph2_q;

  always_comb begin
    kp_s = {1'b0, gains_i.kp};
    ki_s = {1'b0, gains_i.ki};
    kd_s = {1'b0, gains_i.kd};
    i_lo = {1'b0, i1_q[IL-1:0]};
    i_hi = i1_q[INTEG_WIDTH-1:IL];
    pp   = kp_s * e1_q;
    pd   = kd_s * d1_q;
    pl   = ki_s * i_lo;
    ph   = ki_s * i_hi;
  end

  // stage 3: partial sums
  logic signed [TW-1:0]  ti, ti3_q;
  logic signed [PSW-1:0] ps, ps3_q;

  always_comb begin
    ti = (TW'(ph2_q) <<< IL) + TW'(pl2_q);
    ps = PSW'(pp2_q) + PSW'(pd2_q);
  end

  // stage 4: limited integral term plus rounding offset
  logic signed [CW-1:0]   tiw, tic;
  logic signed [SUMW-1:0] sum, sum4_q;

  always_comb begin
    tiw = CW'(ti3_q);
    if (tiw > TMAX) begin
      tic = TMAX;
    end else if (tiw < TMIN) begin
      tic = TMIN;
    end else begin
      tic = tiw;
    end
    sum = SUMW'(tic) + SUMW'(ps3_q) + HALF;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      e1_q   <= err;
      d1_q   <= dif;
      i1_q   <= integ_d;
      pp2_q  <= pp;
      pd2_q  <= pd;
      pl2_q  <= pl;
      ph2_q  <= ph;
      ti3_q  <= ti;
      ps3_q  <= ps;
      sum4_q <= sum;
    end
  end

  // round to q8.8 and clamp
  logic signed [SUMW-1:0] vsh, lim, nlim;

  always_comb begin
    vsh  = sum4_q >>> GAIN_FRAC_BITS;
    lim  = SUMW'({1'b0, gains_i.vlim});
    nlim = -lim;
    if (vsh > lim) begin
      vel_o     = lim[VEL_W-1:0];
      clamped_o = 1'b1;
    end else if (vsh < nlim) begin
      vel_o     = nlim[VEL_W-1:0];
      clamped_o = 1'b1;
    end else begin
      vel_o     = vsh[VEL_W-1:0];
      clamped_o = 1'b0;
    end
  end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-axis pid velocity controller. Position words
// go in over a valid/ready channel with random gaps, and velocity words come
// back under random output stalls. Each returned word is compared with a
// bench-side model of both axes, or with a table word where one is given.
// That model covers the error integrator with its saturation, the derivative
// from the previous error, rounding to Q8.8 and the symmetric clamp. Gains,
// setpoints and the limit are reloaded over apb between traffic phases. One
// phase holds a full-scale error with no gaps and ends with a derivative kick.
// ----------------------------------------------------------------------------
module testbench;
  import tapvc_pkg::*;

  localparam int POS_W           = 16;
  localparam int INTEG_W         = 32;
  localparam int FRAC_W          = 12;
  localparam int HALF_PERIOD     = 5;
  localparam int LATENCY         = 5;
  localparam int DRAIN_CYCLES    = 4 * LATENCY;
  localparam int QUIET_LIMIT     = 2000;
  localparam int FIXED_SETS      = 5;
  localparam int GAIN_PHASES     = 10;
  localparam int WORDS_PER_PHASE = 120;
  localparam int SAT_WORDS       = 96;
  localparam int TAIL_WORDS      = 40;
  localparam longint POS_MAX     = (longint'(1) <<< (POS_W - 1)) - 1;
  localparam longint POS_MIN     = -POS_MAX - 1;
  localparam longint INTEG_MAX   = (longint'(1) <<< (INTEG_W - 1)) - 1;
  localparam longint INTEG_MIN   = -INTEG_MAX - 1;
  localparam reg_idx_e REG_SPARE = reg_idx_e'(REG_VEL_LIMIT + 1);

  typedef struct packed {
    logic [VEL_W-1:0] vel_x;
    logic [VEL_W-1:0] vel_y;
    logic             clamped_x;
    logic             clamped_y;
  } vel_word_t;

  typedef struct {
    logic [POS_W-1:0] mx;
    logic [POS_W-1:0] my;
    logic             pv;
    bit               known;
    vel_word_t        want;
  } tick_row_t;

  typedef struct packed {
    logic [POS_W-1:0]   sp_x;
    logic [POS_W-1:0]   sp_y;
    logic [GAIN_W-1:0]  kp;
    logic [GAIN_W-1:0]  ki;
    logic [GAIN_W-1:0]  kd;
    logic [LIMIT_W-1:0] vlim;
    logic               load_sp;
  } gain_set_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [ADDR_W-1:0]       paddr;
  logic [DATA_W-1:0]       pwdata;
  logic [DATA_W-1:0]       prdata;
  logic                    pready;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic signed [POS_W-1:0] meas_x_i;
  logic signed [POS_W-1:0] meas_y_i;
  logic                    position_valid_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic signed [VEL_W-1:0] vel_x_o;
  logic signed [VEL_W-1:0] vel_y_o;
  logic                    clamped_x_o;
  logic                    clamped_y_o;

  // controller state as the bench sees it
  logic signed [POS_W-1:0]   sp_q [2];
  logic [GAIN_W-1:0]         kp_q;
  logic [GAIN_W-1:0]         ki_q;
  logic [GAIN_W-1:0]         kd_q;
  logic [LIMIT_W-1:0]        vlim_q;
  logic signed [INTEG_W-1:0] integ_q [2];
  logic signed [POS_W:0]     prev_err_q [2];

  vel_word_t pending_vel [$];
  bit        no_idle = 1'b0;
  int        fails = 0;
  int        words_sent = 0;
  int        words_dropped = 0;
  int        results_seen = 0;
  int        clamp_words = 0;
  int        reg_writes = 0;
  int        sets_loaded = 0;
  int        quiet_cycles = 0;

  // after reset, at the field extremes, and with no position
  tick_row_t tick_table [13] = '{
    '{16'h0000, 16'h0000, 1'b1, 1'b1, '{16'h0000, 16'h0000, 1'b0, 1'b0}},
    '{16'h0000, 16'h0000, 1'b0, 1'b0, '0},
    '{16'h8000, 16'h7fff, 1'b1, 1'b1, '{16'h0a00, 16'hf600, 1'b1, 1'b1}},
    '{16'h8000, 16'h7fff, 1'b0, 1'b0, '0},
    '{16'h7fff, 16'h8000, 1'b1, 1'b1, '{16'hf600, 16'h0a00, 1'b1, 1'b1}},
    '{16'h0100, 16'hff00, 1'b1, 1'b0, '0},
    '{16'h0000, 16'h0000, 1'b1, 1'b0, '0},
    '{16'h0080, 16'h0080, 1'b1, 1'b0, '0},
    '{16'h0001, 16'hffff, 1'b1, 1'b0, '0},
    '{16'h5555, 16'haaaa, 1'b1, 1'b0, '0},
    '{16'haaaa, 16'h5555, 1'b0, 1'b0, '0},
    '{16'h0000, 16'h0000, 1'b1, 1'b0, '0},
    '{16'hffff, 16'h0001, 1'b1, 1'b0, '0}
  };

  // defaults, extremes, zero gains, zero limit, gain change with integrators kept
  gain_set_t fixed_sets [FIXED_SETS] = '{
    '{16'h0100, 16'hff00, KP_RST, KI_RST, KD_RST, VLIM_RST, 1'b1},
    '{16'h7fff, 16'h8000, 16'hffff, 16'hffff, 16'hffff, 15'h7fff, 1'b1},
    '{16'h8000, 16'h7fff, 16'h0000, 16'h0000, 16'h0000, 15'h7fff, 1'b1},
    '{16'h0000, 16'h0000, KP_RST, KI_RST, KD_RST, 15'h0000, 1'b1},
    '{16'h0000, 16'h0000, 16'h1000, 16'h0010, 16'h0100, 15'h0800, 1'b0}
  };

  two_axis_pid_velocity_clamp u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .meas_x_i         (meas_x_i),
    .meas_y_i         (meas_y_i),
    .position_valid_i (position_valid_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .vel_x_o          (vel_x_o),
    .vel_y_o          (vel_y_o),
    .clamped_x_o      (clamped_x_o),
    .clamped_y_o      (clamped_y_o)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  function automatic void step_axis(input int ax, input logic signed [POS_W-1:0] meas,
                                    output logic [VEL_W-1:0] vel, output logic clip);
    longint err, dif, acc, total, v, lim;
    err = longint'(sp_q[ax]) - longint'(meas);
    dif = err - longint'(prev_err_q[ax]);
    acc = longint'(integ_q[ax]) + err;
    if (acc > INTEG_MAX) acc = INTEG_MAX;
    else if (acc < INTEG_MIN) acc = INTEG_MIN;
    integ_q[ax] = acc[INTEG_W-1:0];
    prev_err_q[ax] = err[POS_W:0];
    total = longint'(kp_q) * err + longint'(ki_q) * acc + longint'(kd_q) * dif;
    v = (total + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
    lim = longint'(vlim_q);
    clip = 1'b0;
    if (v > lim) begin
      v = lim;
      clip = 1'b1;
    end else if (v < -lim) begin
      v = -lim;
      clip = 1'b1;
    end
    vel = v[VEL_W-1:0];
  endfunction

  function automatic bit predict_velocity(input logic signed [POS_W-1:0] mx, my,
                                          input logic pv, output vel_word_t w);
    w = '0;
    if (!pv) return 1'b0;
    step_axis(0, mx, w.vel_x, w.clamped_x);
    step_axis(1, my, w.vel_y, w.clamped_y);
    return 1'b1;
  endfunction

  function automatic void apply_reg(input reg_idx_e idx, input logic [DATA_W-1:0] data);
    case (idx)
      REG_SETPOINT_X, REG_SETPOINT_Y: begin
        sp_q[idx == REG_SETPOINT_Y] = data[POS_W-1:0];
        integ_q[0] = '0;
        integ_q[1] = '0;
      end
      REG_GAIN_PROP:  kp_q = data[GAIN_W-1:0];
      REG_GAIN_INTEG: ki_q = data[GAIN_W-1:0];
      REG_GAIN_DERIV: kd_q = data[GAIN_W-1:0];
      REG_VEL_LIMIT:  vlim_q = data[LIMIT_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_meas(input logic signed [POS_W-1:0] sp);
    longint m;
    if ($urandom_range(0, 2) == 0) return POS_W'($urandom());
    m = longint'(sp) + longint'($urandom_range(0, 1024)) - 512;
    if (m > POS_MAX) m = POS_MAX;
    if (m < POS_MIN) m = POS_MIN;
    return m[POS_W-1:0];
  endfunction

  function automatic void check_field(input string name, input logic [VEL_W-1:0] want, got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      fails++;
    end
  endfunction

  // unused upper data bits carry noise
  task automatic apb_write(input reg_idx_e idx, input logic [GAIN_W-1:0] val);
    logic [DATA_W-1:0] data;
    data = $urandom();
    if (idx == REG_VEL_LIMIT) data[LIMIT_W-1:0] = val[LIMIT_W-1:0];
    else data[GAIN_W-1:0] = val;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    apply_reg(idx, data);
    reg_writes++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_gains(input gain_set_t s);
    if (s.load_sp) begin
      apb_write(REG_SETPOINT_X, s.sp_x);
      apb_write(REG_SETPOINT_Y, s.sp_y);
    end
    apb_write(REG_GAIN_PROP, s.kp);
    apb_write(REG_GAIN_INTEG, s.ki);
    apb_write(REG_GAIN_DERIV, s.kd);
    apb_write(REG_VEL_LIMIT, GAIN_W'(s.vlim));
    sets_loaded++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_vel.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_tick(input logic [POS_W-1:0] mx, my, input logic pv,
                           input bit known, input vel_word_t want);
    int gap;
    vel_word_t w;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    meas_x_i         <= mx;
    meas_y_i         <= my;
    position_valid_i <= pv;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
    if (predict_velocity(mx, my, pv, w)) pending_vel.push_back(known ? want : w);
    else words_dropped++;
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni || psel || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : result_side
    int stall;
    vel_word_t got, want;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got = {vel_x_o, vel_y_o, clamped_x_o, clamped_y_o};
      results_seen++;
      if (got.clamped_x || got.clamped_y) clamp_words++;
      if (pending_vel.size() == 0) begin
        $error("unexpected word: vel_x %0d, vel_y %0d", $signed(got.vel_x), $signed(got.vel_y));
        fails++;
      end else begin
        want = pending_vel.pop_front();
        check_field("vel_x", want.vel_x, got.vel_x);
        check_field("vel_y", want.vel_y, got.vel_y);
        check_field("clamped_x", VEL_W'(want.clamped_x), VEL_W'(got.clamped_x));
        check_field("clamped_y", VEL_W'(want.clamped_y), VEL_W'(got.clamped_y));
      end
    end
  end

  initial begin : stimulus
    gain_set_t s;
    rst_ni           <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    in_valid_i       <= 1'b0;
    meas_x_i         <= '0;
    meas_y_i         <= '0;
    position_valid_i <= 1'b0;
    sp_q[0] = '0;
    sp_q[1] = '0;
    kp_q = KP_RST;
    ki_q = KI_RST;
    kd_q = KD_RST;
    vlim_q = VLIM_RST;
    integ_q[0] = '0;
    integ_q[1] = '0;
    prev_err_q[0] = '0;
    prev_err_q[1] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (tick_table[i])
      send_tick(tick_table[i].mx, tick_table[i].my, tick_table[i].pv,
                tick_table[i].known, tick_table[i].want);

    for (int p = 0; p < GAIN_PHASES; p++) begin
      settle();
      if (p < FIXED_SETS) begin
        s = fixed_sets[p];
      end else begin
        s.sp_x    = POS_W'($urandom());
        s.sp_y    = POS_W'($urandom());
        s.kp      = GAIN_W'($urandom()) >> $urandom_range(0, 8);
        s.ki      = GAIN_W'($urandom()) >> $urandom_range(0, 12);
        s.kd      = GAIN_W'($urandom()) >> $urandom_range(0, 8);
        s.vlim    = LIMIT_W'($urandom()) >> $urandom_range(0, 6);
        s.load_sp = 1'($urandom_range(0, 1));
      end
      load_gains(s);
      if (p == 0) apb_write(REG_SPARE, GAIN_W'($urandom()));
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
        send_tick(pick_meas(sp_q[0]), pick_meas(sp_q[1]), $urandom_range(0, 9) != 0,
                  1'b0, '0);
      end
    end

    // full-scale error back to back, then a derivative kick
    settle();
    no_idle = 1'b1;
    load_gains('{16'h7fff, 16'h8000, 16'h0000, 16'h0001, 16'h8000, 15'h7fff, 1'b1});
    repeat (SAT_WORDS) send_tick(16'h8000, 16'h7fff, 1'b1, 1'b0, '0);
    send_tick(16'h7fff, 16'h8000, 1'b1, 1'b0, '0);
    no_idle = 1'b0;
    repeat (TAIL_WORDS)
      send_tick(pick_meas(sp_q[0]), pick_meas(sp_q[1]), $urandom_range(0, 9) != 0, 1'b0, '0);

    settle();
    $display("covered %0d position words (%0d without a fix) over %0d gain settings",
             words_sent, words_dropped, sets_loaded);
    $display("checked %0d velocity words, %0d with an axis at the limit, %0d register writes",
             results_seen, clamp_words, reg_writes);
    if (fails == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: two_axis_pid_velocity_clamp.f
sv/tapvc_pkg.sv
sv/tapvc_regs.sv
sv/tapvc_lane.sv
sv/two_axis_pid_velocity_clamp.sv
tb/testbench.sv
